>>> rtl/priority_queue_extract_max_assert.svh
// ----------------------------------------------------------------------------
// priority_queue_extract_max_assert
// Assertion macros used by the priority queue datapath.
// Each macro expects signals named clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_EXTRACT_MAX_ASSERT_SVH
`define PRIORITY_QUEUE_EXTRACT_MAX_ASSERT_SVH

// Condition must hold on every clock edge outside reset.
`define PQEM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PQEM_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PQEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pqem_pkg.sv
// ----------------------------------------------------------------------------
// pqem_pkg
// Shared constants, codes and controller/datapath interface types for the
// ordered-list priority queue.
// ----------------------------------------------------------------------------
package pqem_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int ENTRY_W  = 2 * DATA_W;

    // request opcodes
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_CHANGE  = 2'd2;
    localparam logic [1:0] OP_EXTRACT = 2'd3;

    // response status codes
    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [DATA_W-1:0] VALUE_NONE = '1;

    typedef struct packed {
        logic        [DATA_W-1:0] id;
        logic signed [DATA_W-1:0] pri;
    } entry_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_CLEAR,
        PTR_INC,
        PTR_BEST
    } ptr_op_t;

    typedef enum logic [1:0] {
        WR_HOLD,
        WR_CHANGE,
        WR_RDATA
    } wr_sel_t;

    typedef enum logic [2:0] {
        RES_DONE,
        RES_FULL,
        RES_MISS,
        RES_LKP_HIT,
        RES_LKP_MISS,
        RES_EMPTY,
        RES_EXTRACT
    } res_sel_t;

    typedef struct packed {
        logic     accept;
        ptr_op_t  ptr_op;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     wr_back;
        logic     hold_load;
        logic     best_upd;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_load;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic full;
        logic empty;
        logic pri_lower;
        logic id_match;
        logic best_take;
    } dp_status_t;

endpackage

>>> rtl/pqem_ram.sv
// ----------------------------------------------------------------------------
// pqem_ram
// Generic single-write, single-read RAM with registered read data
// (read returns the old contents on a same-address write).
// ----------------------------------------------------------------------------
module pqem_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/pqem_dp.sv
// ----------------------------------------------------------------------------
// pqem_dp
// Datapath: entry RAM, scan pointer, entry count, carry/best registers and
// the response registers.
// ----------------------------------------------------------------------------
module pqem_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pqem_pkg::ctrl_cmd_t         cmd,
    output pqem_pkg::dp_status_t        sts,
    input  logic [31:0]                 entry_id,
    input  logic signed [31:0]          priority_value,
    output logic [1:0]                  status,
    output logic signed [31:0]          result_id,
    output logic signed [31:0]          result_priority
);

    import pqem_pkg::*;

    `include "priority_queue_extract_max_assert.svh"

    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         best_pos_reg;
    entry_t                   best_reg;
    entry_t                   hold_reg;
    logic [DATA_W-1:0]        id_reg;
    logic signed [DATA_W-1:0] pri_reg;
    logic [1:0]               status_reg;
    logic [DATA_W-1:0]        rid_reg;
    logic [DATA_W-1:0]        rpri_reg;

    entry_t              rdata;
    logic [ENTRY_W-1:0]  ram_rd_data;
    entry_t              wr_data;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CNT_W-1:0]    ptr_m1;

    always_comb
    begin
        case (cmd.ptr_op)
            PTR_HOLD:  ptr_next = ptr_reg;
            PTR_CLEAR: ptr_next = '0;
            PTR_INC:   ptr_next = ptr_reg + CNT_W'(1);
            PTR_BEST:  ptr_next = best_pos_reg + CNT_W'(1);
            default:   ptr_next = ptr_reg;
        endcase
    end

    // read address follows the pointer's next value, so rdata is mem[ptr_reg]
    assign rdata  = entry_t'(ram_rd_data);
    assign ptr_m1 = ptr_reg - CNT_W'(1);

    always_comb
    begin
        case (cmd.wr_sel)
            WR_HOLD:   wr_data = hold_reg;
            WR_CHANGE: wr_data = '{id: rdata.id, pri: pri_reg};
            WR_RDATA:  wr_data = rdata;
            default:   wr_data = hold_reg;
        endcase
    end

    assign wr_addr = cmd.wr_back ? ptr_m1[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];

    pqem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_next[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign sts.in_range  = (ptr_reg < count_reg);
    assign sts.full      = (count_reg == CNT_W'(CAPACITY));
    assign sts.empty     = (count_reg == '0);
    assign sts.pri_lower = (rdata.pri < pri_reg);
    assign sts.id_match  = (rdata.id == id_reg);
    assign sts.best_take = (ptr_reg == '0) || (rdata.pri > best_reg.pri);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            id_reg   <= entry_id;
            pri_reg  <= priority_value;
            hold_reg <= '{id: entry_id, pri: priority_value};
        end
        else if (cmd.hold_load)
        begin
            hold_reg <= rdata;
        end

        if (cmd.best_upd)
        begin
            best_reg     <= rdata;
            best_pos_reg <= ptr_reg;
        end

        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_DONE:
                begin
                    status_reg <= STATUS_DONE;
                    rid_reg    <= '0;
                    rpri_reg   <= '0;
                end
                RES_FULL:
                begin
                    status_reg <= STATUS_FULL;
                    rid_reg    <= '0;
                    rpri_reg   <= '0;
                end
                RES_MISS:
                begin
                    status_reg <= STATUS_MISS;
                    rid_reg    <= '0;
                    rpri_reg   <= '0;
                end
                RES_LKP_HIT:
                begin
                    status_reg <= STATUS_DONE;
                    rid_reg    <= id_reg;
                    rpri_reg   <= rdata.pri;
                end
                RES_LKP_MISS:
                begin
                    status_reg <= STATUS_MISS;
                    rid_reg    <= id_reg;
                    rpri_reg   <= VALUE_NONE;
                end
                RES_EMPTY:
                begin
                    status_reg <= STATUS_MISS;
                    rid_reg    <= VALUE_NONE;
                    rpri_reg   <= VALUE_NONE;
                end
                RES_EXTRACT:
                begin
                    status_reg <= STATUS_DONE;
                    rid_reg    <= best_reg.id;
                    rpri_reg   <= best_reg.pri;
                end
                default:
                begin
                    status_reg <= STATUS_DONE;
                    rid_reg    <= '0;
                    rpri_reg   <= '0;
                end
            endcase
        end
    end

    assign status          = status_reg;
    assign result_id       = rid_reg;
    assign result_priority = rpri_reg;

    `PQEM_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PQEM_ASSERT_IMPLIES(a_inc_not_full, cmd.cnt_inc, !sts.full, "insert into full store")
    `PQEM_ASSERT_IMPLIES(a_dec_not_empty, cmd.cnt_dec, !sts.empty, "remove from empty store")
    `PQEM_ASSERT_IMPLIES(a_wr_in_list, cmd.wr_en, ptr_reg <= count_reg, "write past list end")
    `PQEM_ASSERT_NEXT(a_inc_nonempty, cmd.cnt_inc, !sts.empty, "count did not grow")

endmodule

>>> rtl/pqem_ctrl.sv
// ----------------------------------------------------------------------------
// pqem_ctrl
// Controller: sequences the list scans and shifts for each request and
// drives the request/response handshakes.
// ----------------------------------------------------------------------------
module pqem_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           op,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  pqem_pkg::dp_status_t sts,
    output pqem_pkg::ctrl_cmd_t  cmd
);

    import pqem_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_FIND,
        S_INS_SHIFT,
        S_LKP_FIND,
        S_CHG_FIND,
        S_EXT_FIND,
        S_EXT_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ptr_op = PTR_CLEAR;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    case (op)
                        OP_INSERT: state_next = S_INS_FIND;
                        OP_LOOKUP: state_next = S_LKP_FIND;
                        OP_CHANGE: state_next = S_CHG_FIND;
                        default:   state_next = S_EXT_FIND;
                    endcase
                end
            end
            S_INS_FIND:
            begin
                if (sts.full)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FULL;
                    state_next   = S_DONE;
                end
                else if (!sts.in_range)
                begin
                    // append at the end
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_HOLD;
                    cmd.cnt_inc  = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_DONE;
                    state_next   = S_DONE;
                end
                else if (sts.pri_lower)
                begin
                    // place new entry, carry the displaced one forward
                    cmd.wr_en     = 1'b1;
                    cmd.wr_sel    = WR_HOLD;
                    cmd.hold_load = 1'b1;
                    cmd.ptr_op    = PTR_INC;
                    state_next    = S_INS_SHIFT;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            S_INS_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_HOLD;
                if (sts.in_range)
                begin
                    cmd.hold_load = 1'b1;
                    cmd.ptr_op    = PTR_INC;
                end
                else
                begin
                    cmd.cnt_inc  = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_DONE;
                    state_next   = S_DONE;
                end
            end
            S_LKP_FIND:
            begin
                if (!sts.in_range)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_LKP_MISS;
                    state_next   = S_DONE;
                end
                else if (sts.id_match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_LKP_HIT;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            S_CHG_FIND:
            begin
                if (!sts.in_range)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_MISS;
                    state_next   = S_DONE;
                end
                else if (sts.id_match)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_CHANGE;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_DONE;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            S_EXT_FIND:
            begin
                if (sts.empty)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_EMPTY;
                    state_next   = S_DONE;
                end
                else if (sts.in_range)
                begin
                    cmd.best_upd = sts.best_take;
                    cmd.ptr_op   = PTR_INC;
                end
                else
                begin
                    // restart just past the winner to close the gap
                    cmd.ptr_op   = PTR_BEST;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_EXTRACT;
                    state_next   = S_EXT_SHIFT;
                end
            end
            S_EXT_SHIFT:
            begin
                if (sts.in_range)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_RDATA;
                    cmd.wr_back = 1'b1;
                    cmd.ptr_op  = PTR_INC;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.ptr_op = PTR_CLEAR;
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/priority_queue_extract_max.sv
// ----------------------------------------------------------------------------
// priority_queue_extract_max
// Bounded priority queue of (id, priority) entries kept in list order.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY (64) entries in one RAM, front of the list at
// address 0, and serves one request at a time: a request is taken when the
// block is idle, and its single response stays on the output until taken.
// Every operation walks the list one entry per cycle through the RAM's one
// read port, with at most one write per cycle, so latency grows with the
// number of stored entries N. Insert scans to the insertion point, then
// carries the tail back one slot (a full queue answers without a scan);
// lookup and change stop at the first matching id; extract makes a full scan
// for the first highest priority, then shifts the tail forward (an empty
// queue answers without a scan). The response handshake returns the block
// to idle before the next request is taken. There is no clearing pass after
// reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module priority_queue_extract_max (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         op,
    input  logic signed [31:0] entry_id,
    input  logic signed [31:0] priority_value,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [1:0]         status,
    output logic signed [31:0] result_id,
    output logic signed [31:0] result_priority
);

    import pqem_pkg::*;

    // command and status buses between controller and datapath
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // controller: one state per scan/shift phase of each opcode
    pqem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .op        (op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: entry RAM, pointer, count and response registers
    pqem_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .entry_id        (entry_id),
        .priority_value  (priority_value),
        .status          (status),
        .result_id       (result_id),
        .result_priority (result_priority)
    );

endmodule

>>> test/priority_queue_extract_max_tb.sv
// ----------------------------------------------------------------------------
// priority_queue_extract_max_tb
// Drives random and directed queue requests into the ordered-list priority
// queue, mirrors the list contents in a shadow copy to predict each response,
// and compares every response field against the prediction in request order.
// ----------------------------------------------------------------------------
module priority_queue_extract_max_tb;

    import pqem_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_COUNT = 1500;
    localparam int LONG_HOLD    = 400;
    // longest operation (full extract) plus the response handshake
    localparam int SETTLE       = 2 * CAPACITY + 20;

    localparam logic [31:0] PRI_MIN = 32'h8000_0000;
    localparam logic [31:0] PRI_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] id;
        logic [31:0] pri;
    } rsp_t;

    // Shadow copy of the list; predicts each response and checks it.
    class pq_mirror;
        entry_t slots [CAPACITY];
        int     count;
        rsp_t   pending_rsp [$];
        int     errors;
        int     op_seen [4];
        int     full_drops;
        int     misses;
        int     empty_pops;
        int     peak;

        function new();
            count      = 0;
            errors     = 0;
            full_drops = 0;
            misses     = 0;
            empty_pops = 0;
            peak       = 0;
            foreach (op_seen[i])
                op_seen[i] = 0;
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        function logic [31:0] id_at(int k);
            return slots[k].id;
        endfunction

        function int find_id(logic [31:0] id);
            for (int i = 0; i < count; i++)
                if (slots[i].id == id)
                    return i;
            return -1;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", what);
        endfunction

        // Called on each accepted request: update the shadow list and queue
        // up the response the block must give for it.
        function void apply_request(logic [1:0] kind, logic [31:0] id, logic [31:0] pri);
            rsp_t want;
            int   pos;
            int   best;
            want.status = STATUS_DONE;
            want.id     = '0;
            want.pri    = '0;
            op_seen[kind]++;
            case (kind)
                OP_INSERT:
                begin
                    if (count >= CAPACITY)
                    begin
                        want.status = STATUS_FULL;
                        full_drops++;
                    end
                    else
                    begin
                        // ahead of the first strictly lower priority
                        pos = count;
                        for (int i = 0; i < count; i++)
                        begin
                            if ($signed(slots[i].pri) < $signed(pri))
                            begin
                                pos = i;
                                break;
                            end
                        end
                        for (int i = count; i > pos; i--)
                            slots[i] = slots[i-1];
                        slots[pos].id  = id;
                        slots[pos].pri = pri;
                        count++;
                        if (count > peak)
                            peak = count;
                    end
                end
                OP_LOOKUP:
                begin
                    pos     = find_id(id);
                    want.id = id;
                    if (pos >= 0)
                        want.pri = slots[pos].pri;
                    else
                    begin
                        want.status = STATUS_MISS;
                        want.pri    = VALUE_NONE;
                        misses++;
                    end
                end
                OP_CHANGE:
                begin
                    pos = find_id(id);
                    if (pos >= 0)
                        slots[pos].pri = pri;
                    else
                    begin
                        want.status = STATUS_MISS;
                        misses++;
                    end
                end
                default:
                begin
                    if (count == 0)
                    begin
                        want.status = STATUS_MISS;
                        want.id     = VALUE_NONE;
                        want.pri    = VALUE_NONE;
                        empty_pops++;
                    end
                    else
                    begin
                        // first entry holding the highest priority wins ties
                        best = 0;
                        for (int i = 1; i < count; i++)
                            if ($signed(slots[i].pri) > $signed(slots[best].pri))
                                best = i;
                        want.id  = slots[best].id;
                        want.pri = slots[best].pri;
                        for (int i = best; i + 1 < count; i++)
                            slots[i] = slots[i+1];
                        count--;
                    end
                end
            endcase
            pending_rsp.push_back(want);
        endfunction

        function void check_response(logic [1:0] st, logic [31:0] rid, logic [31:0] rpri);
            rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                flag($sformatf("response with nothing outstanding: status %0d id %h pri %h",
                               st, rid, rpri));
                return;
            end
            want = pending_rsp.pop_front();
            if (st !== want.status || rid !== want.id || rpri !== want.pri)
                flag($sformatf("expected status %0d id %h pri %h, got status %0d id %h pri %h",
                               want.status, want.id, want.pri, st, rid, rpri));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [1:0]         op;
    logic signed [31:0] entry_id;
    logic signed [31:0] priority_value;
    logic               rsp_valid;
    logic               rsp_ready;
    logic [1:0]         status;
    logic signed [31:0] result_id;
    logic signed [31:0] result_priority;

    pq_mirror queue_mirror = new();
    bit       idle_on      = 1'b1;
    int       hold_request = 0;   // one-shot long response stall
    int       cycles       = 0;

    priority_queue_extract_max uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .op              (op),
        .entry_id        (entry_id),
        .priority_value  (priority_value),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .status          (status),
        .result_id       (result_id),
        .result_priority (result_priority)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one request and return at the edge where it is taken. Valid stays
    // high afterwards so a back-to-back request reuses it without a dip.
    task automatic send_request(logic [1:0] kind, logic [31:0] id, logic [31:0] pri);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        op             <= kind;
        entry_id       <= id;
        priority_value <= pri;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        queue_mirror.apply_request(kind, id, pri);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (queue_mirror.pending() != 0);
    endtask

    function automatic logic [1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return r < 70 ? OP_INSERT : r < 80 ? OP_LOOKUP : r < 90 ? OP_CHANGE
                                                                       : OP_EXTRACT;
            1:       return r < 15 ? OP_INSERT : r < 30 ? OP_LOOKUP : r < 40 ? OP_CHANGE
                                                                       : OP_EXTRACT;
            default: return r < 35 ? OP_INSERT : r < 55 ? OP_LOOKUP : r < 70 ? OP_CHANGE
                                                                       : OP_EXTRACT;
        endcase
    endfunction

    // Mostly ids already stored, so lookup and change hit; some from a small
    // pool for duplicates and misses; some fully random.
    function automatic logic [31:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && queue_mirror.count > 0)
            return queue_mirror.id_at($urandom_range(0, queue_mirror.count - 1));
        else if (r < 9)
            return int'($urandom_range(0, 15)) - 8;
        return $urandom;
    endfunction

    // Narrow band for ties, full range, and the extremes.
    function automatic logic [31:0] pick_pri();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return int'($urandom_range(0, 8)) - 4;
        else if (r < 8)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return PRI_MIN;
            1:       return PRI_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Response side: random stall before each response, or a long hold on
    // request from the stimulus side.
    initial
    begin : rsp_side
        int stall;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else
                stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            queue_mirror.check_response(status, result_id, result_priority);
        end
    end

    initial
    begin : req_side
        logic [1:0]  kind;
        logic [31:0] id_v;
        logic [31:0] pri_v;
        int          phase;
        int          mode;
        int          n;
        int          sent;
        rst_n          <= 1'b0;
        req_valid      <= 1'b0;
        op             <= OP_INSERT;
        entry_id       <= '0;
        priority_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: every op misses
        send_request(OP_EXTRACT, 32'd0, 32'd0);
        send_request(OP_LOOKUP, 32'd5, 32'd0);
        send_request(OP_CHANGE, 32'd5, 32'd9);
        // extreme ids and priorities, ties, a duplicate id
        send_request(OP_INSERT, 32'h7FFF_FFFF, PRI_MIN);
        send_request(OP_INSERT, 32'h8000_0000, PRI_MAX);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_INSERT, 32'd0, 32'd0);
        send_request(OP_INSERT, 32'd1, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'd0, 32'd5);
        send_request(OP_LOOKUP, 32'd0, 32'd0);
        send_request(OP_LOOKUP, 32'h8000_0000, 32'd0);
        send_request(OP_LOOKUP, 32'd12345, 32'd0);
        // raise a middle entry to the top without reordering it
        send_request(OP_CHANGE, 32'hFFFF_FFFF, PRI_MAX);
        send_request(OP_CHANGE, 32'd999, 32'd1);
        send_request(OP_EXTRACT, 32'd0, 32'd0);
        send_request(OP_EXTRACT, 32'd0, 32'd0);
        send_request(OP_CHANGE, 32'd1, PRI_MAX);
        send_request(OP_LOOKUP, 32'd1, 32'd0);
        // drain, then two extracts past empty
        repeat (5) send_request(OP_EXTRACT, 32'd0, 32'd0);
        send_request(OP_EXTRACT, 32'd0, 32'd0);
        wait_drained();

        // Random phases: fill-heavy, drain-heavy, balanced. Fill phases push
        // the queue to capacity so inserts get dropped.
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_COUNT)
        begin
            mode    = phase % 3;
            idle_on = (phase % 4 != 3);
            if (phase == 2)
                hold_request = LONG_HOLD;
            if (phase == 1 || phase % 5 == 4)
                wait_drained();
            n = $urandom_range(100, 180);
            for (int k = 0; k < n; k++)
            begin
                kind  = pick_op(mode);
                id_v  = pick_id();
                pri_v = pick_pri();
                send_request(kind, id_v, pri_v);
                sent++;
            end
            phase++;
        end
        idle_on = 1'b1;

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d inserts (%0d dropped while full), %0d lookups, %0d changes",
                 queue_mirror.op_seen[OP_INSERT], queue_mirror.full_drops,
                 queue_mirror.op_seen[OP_LOOKUP], queue_mirror.op_seen[OP_CHANGE]);
        $display("%0d extracts (%0d on empty), %0d id misses, peak depth %0d, %0d errors",
                 queue_mirror.op_seen[OP_EXTRACT], queue_mirror.empty_pops,
                 queue_mirror.misses, queue_mirror.peak, queue_mirror.errors);
        if (queue_mirror.errors == 0 && queue_mirror.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
